[hw/rtl/assert_macros.svh]
// Assertion macros used by the text buffer core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CTB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define CTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/ctb_pkg.sv]
// Types, codes and sizes shared by the cursor text buffer modules.
package ctb_pkg;

    // Store size, its address width, and the count and position widths
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 11;
    localparam int POS_W    = 10;

    // Opcodes
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_LEFT   = 3'd1;
    localparam logic [2:0] OP_RIGHT  = 3'd2;
    localparam logic [2:0] OP_BKSP   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_IGNORE = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [7:0]       char_in;
        logic [POS_W-1:0] position;
    } t_in;

    typedef struct packed {
        logic [7:0]       char_out;
        logic [1:0]       status;
        logic [CNT_W-1:0] cursor_pos;
        logic [CNT_W-1:0] text_length;
    } t_out;

endpackage

[hw/rtl/ctb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module ctb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/ctb_core.sv]
// Gap buffer engine: cursor counters, command sequencer and the text store.
`include "assert_macros.svh"

module ctb_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ctb_pkg::t_in  i_in_data,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output ctb_pkg::t_out o_res_data
);
    import ctb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_HOLD  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_right, n_right;
    logic [2:0]       r_op, n_op;
    t_out             r_hold;

    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  cap_c;
    logic [CNT_W-1:0]  top_base;
    logic [CNT_W-1:0]  pos_ext;
    logic [CNT_W-1:0]  right_addr;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic              res_now;
    logic [7:0]        res_char;
    logic [1:0]        res_status;
    t_out              res_c;

    // gap geometry
    assign len        = r_left + r_right;
    assign cap_c      = CNT_W'(CAPACITY);
    assign top_base   = cap_c - r_right;
    assign pos_ext    = CNT_W'(i_in_data.position);
    assign right_addr = (top_base - r_left) + pos_ext;

    ctb_ram #(
        .WIDTH (8),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // command sequencer: edits finish in S_IDLE, moves and reads go on through S_FETCH
    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_right    = r_right;
        n_op       = r_op;
        ram_we     = 1'b0;
        ram_waddr  = r_left[ADDR_W-1:0];
        ram_wdata  = i_in_data.char_in;
        ram_raddr  = r_left[ADDR_W-1:0];
        res_now    = 1'b0;
        res_char   = 8'd0;
        res_status = ST_DONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_in_data.opcode;
                    unique case (i_in_data.opcode)
                        OP_INSERT: begin
                            res_now = 1'b1;
                            if (len >= cap_c) begin
                                res_status = ST_FULL;
                            end else begin
                                ram_we = 1'b1;
                                n_left = r_left + 1'b1;
                            end
                        end
                        OP_LEFT: begin
                            if (r_left == '0) begin
                                res_now    = 1'b1;
                                res_status = ST_IGNORE;
                            end else begin
                                ram_raddr = ADDR_W'(r_left - 1'b1);
                                n_state   = S_FETCH;
                            end
                        end
                        OP_RIGHT: begin
                            if (r_right == '0) begin
                                res_now    = 1'b1;
                                res_status = ST_IGNORE;
                            end else begin
                                ram_raddr = ADDR_W'(top_base);
                                n_state   = S_FETCH;
                            end
                        end
                        OP_BKSP: begin
                            res_now = 1'b1;
                            if (r_left == '0) begin
                                res_status = ST_IGNORE;
                            end else begin
                                n_left = r_left - 1'b1;
                            end
                        end
                        OP_READ: begin
                            if (pos_ext >= len) begin
                                res_now    = 1'b1;
                                res_status = ST_RANGE;
                            end else begin
                                ram_raddr = (pos_ext < r_left) ? ADDR_W'(pos_ext)
                                                               : ADDR_W'(right_addr);
                                n_state   = S_FETCH;
                            end
                        end
                        default: begin
                            res_now    = 1'b1;
                            res_status = ST_IGNORE;
                        end
                    endcase
                end
            end
            S_FETCH: begin
                res_now   = 1'b1;
                ram_wdata = ram_rdata;
                unique case (r_op)
                    OP_LEFT: begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(top_base - 1'b1);
                        n_left    = r_left - 1'b1;
                        n_right   = r_right + 1'b1;
                    end
                    OP_RIGHT: begin
                        ram_we    = 1'b1;
                        ram_waddr = r_left[ADDR_W-1:0];
                        n_left    = r_left + 1'b1;
                        n_right   = r_right - 1'b1;
                    end
                    default: begin
                        res_char = ram_rdata;
                    end
                endcase
            end
            S_HOLD: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (res_now) begin
            n_state = i_res_ready ? S_IDLE : S_HOLD;
        end
    end

    // result beat, built from the counters after this step
    always_comb begin
        res_c.char_out    = res_char;
        res_c.status      = res_status;
        res_c.cursor_pos  = n_left;
        res_c.text_length = n_left + n_right;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_left  <= '0;
            r_right <= '0;
            r_op    <= OP_INSERT;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            r_right <= n_right;
            r_op    <= n_op;
        end
    end

    // parked result while the output register is full
    always_ff @(posedge i_clk) begin
        if (res_now && !i_res_ready) begin
            r_hold <= res_c;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_res_valid = res_now || (r_state == S_HOLD);
    assign o_res_data  = (r_state == S_HOLD) ? r_hold : res_c;

    `CTB_ASSERT_IMPLY(a_len_in_cap, i_clk, i_rst_n, 1'b1,
        (12'(r_left) + 12'(r_right)) <= 12'(CAPACITY))
    `CTB_ASSERT_NEXT(a_fetch_one_cycle, i_clk, i_rst_n, r_state == S_FETCH,
        r_state != S_FETCH)
    `CTB_ASSERT_IMPLY(a_no_write_in_hold, i_clk, i_rst_n, r_state == S_HOLD, !ram_we)
    `CTB_ASSERT_IMPLY(a_left_move_has_char, i_clk, i_rst_n,
        (r_state == S_FETCH) && (r_op == OP_LEFT), r_left != '0)

endmodule

[hw/rtl/cursor_text_buffer_top.sv]
// Cursor text buffer top level: command channel, engine and result register.
//
// Usage: a gap buffer text editor of 1024 characters. Each command beat on
// the input channel (i_in_valid / o_in_stall, payload i_in_data) carries an
// opcode: insert, cursor left, cursor right, backspace or read position.
// Every command yields exactly one result beat on the output channel
// (o_out_valid / i_out_stall, payload o_out_data) with the character read,
// a status, the cursor position and the text length after the command.
// Insert, backspace, refused and ignored commands finish in the engine's
// idle state; cursor moves and in-range reads go on through a fetch state,
// since they wait on the registered read of the text store before writing
// or answering. The result lands in the output register at the end of that
// work, and input stalls while a move or read is in the fetch state.
// A stalled receiver holds the output register; the engine still takes the
// next command and parks its result, then stalls input until it drains.
// Reset (synchronous, active low) empties the text and the output register;
// the store contents are left as they are and never read before written.
module cursor_text_buffer_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  ctb_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output ctb_pkg::t_out o_out_data
);
    import ctb_pkg::*;

    logic r_out_valid;
    t_out r_out_data;
    logic res_valid;
    logic res_ready;
    t_out res_data;

    ctb_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_data  (res_data)
    );

    // output register takes a beat when empty or draining this cycle
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_data <= res_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the cursor text buffer: scoreboard, stimulus and checks.
module tb;
    import ctb_pkg::*;

    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int IDLE_LIMIT  = 5000;   // watchdog: cycles with no beat on either side
    localparam int TAIL_CYCLES = 8;      // settle time after the last result
    localparam int MAX_REPORTS = 40;     // cap on printed mismatch lines

    // Opcodes the block does not define; it answers them as ignored
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    // Gap buffer predictor plus the queue of results still owed by the block
    class gap_buffer_scoreboard;
        logic [7:0]  text_mem [CAPACITY];
        int unsigned left_len;
        int unsigned right_len;
        t_out        expected_results [$];
        int          errors;

        function new();
            left_len  = 0;
            right_len = 0;
            errors    = 0;
        endfunction

        function int unsigned text_total();
            return left_len + right_len;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("ERROR: %s", msg);
        endtask

        // Apply one accepted command and queue the result it must produce
        function void note_command(t_in cmd);
            t_out        res;
            int unsigned total;
            total      = left_len + right_len;
            res        = '0;
            res.status = ST_DONE;
            case (cmd.opcode)
                OP_INSERT: begin
                    if (total >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        text_mem[left_len] = cmd.char_in;
                        left_len++;
                    end
                end
                OP_LEFT: begin
                    if (left_len == 0) begin
                        res.status = ST_IGNORE;
                    end else begin
                        // carry the char before the cursor to the top of the gap
                        text_mem[CAPACITY - right_len - 1] = text_mem[left_len - 1];
                        left_len--;
                        right_len++;
                    end
                end
                OP_RIGHT: begin
                    if (right_len == 0) begin
                        res.status = ST_IGNORE;
                    end else begin
                        text_mem[left_len] = text_mem[CAPACITY - right_len];
                        left_len++;
                        right_len--;
                    end
                end
                OP_BKSP: begin
                    if (left_len == 0)
                        res.status = ST_IGNORE;
                    else
                        left_len--;
                end
                OP_READ: begin
                    if (cmd.position >= total)
                        res.status = ST_RANGE;
                    else if (cmd.position < left_len)
                        res.char_out = text_mem[cmd.position];
                    else
                        res.char_out = text_mem[CAPACITY - right_len
                                                + (cmd.position - left_len)];
                end
                default: res.status = ST_IGNORE;
            endcase
            res.cursor_pos  = CNT_W'(left_len);
            res.text_length = CNT_W'(left_len + right_len);
            expected_results.push_back(res);
        endfunction

        // Compare one result beat with the oldest expectation
        task check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                report($sformatf("result beat with nothing expected: %h", got));
                return;
            end
            want = expected_results.pop_front();
            if (got.char_out !== want.char_out)
                report($sformatf("char_out got %0d expected %0d",
                                 got.char_out, want.char_out));
            if (got.status !== want.status)
                report($sformatf("status got %0d expected %0d",
                                 got.status, want.status));
            if (got.cursor_pos !== want.cursor_pos)
                report($sformatf("cursor_pos got %0d expected %0d",
                                 got.cursor_pos, want.cursor_pos));
            if (got.text_length !== want.text_length)
                report($sformatf("text_length got %0d expected %0d",
                                 got.text_length, want.text_length));
        endtask
    endclass

    // Clock, reset and block ports
    logic  i_clk     = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    t_in   in_data   = '0;
    logic  out_stall = 1'b0;
    logic  in_stall;
    logic  out_valid;
    t_out  out_data;

    gap_buffer_scoreboard board;
    int    burst_left  = 0;
    int    idle_cycles = 0;
    bit    hold_req    = 1'b0;

    always #6 i_clk = ~i_clk;

    cursor_text_buffer_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    function automatic t_in mk(logic [2:0] op, logic [7:0] ch, logic [POS_W-1:0] pos);
        t_in c;
        c.opcode   = op;
        c.char_in  = ch;
        c.position = pos;
        return c;
    endfunction

    // Random command; weights in percent for insert and backspace, the rest
    // is split among moves, reads and spare opcodes
    function automatic t_in random_cmd(int ins_w, int bk_w);
        t_in         c;
        int          roll;
        int          span;
        int          pick;
        int unsigned total;
        c.char_in  = 8'($urandom_range(0, 255));
        c.position = POS_W'($urandom_range(0, 1023));
        total      = board.text_total();
        roll       = $urandom_range(0, 99);
        if (roll < ins_w) begin
            c.opcode = OP_INSERT;
        end else if (roll < ins_w + bk_w) begin
            c.opcode = OP_BKSP;
        end else begin
            span = 100 - ins_w - bk_w;
            pick = (roll - ins_w - bk_w) * 20 / span;
            if (pick < 5) begin
                c.opcode = OP_LEFT;
            end else if (pick < 10) begin
                c.opcode = OP_RIGHT;
            end else if (pick < 19) begin
                c.opcode = OP_READ;
                // mostly inside the text, sometimes anywhere
                if (total > 0 && $urandom_range(0, 3) != 0)
                    c.position = POS_W'($urandom_range(0, total - 1));
            end else begin
                c.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
        end
        return c;
    endfunction

    // Send one command beat; bursts of random length with random gaps
    task automatic send_cmd(input t_in cmd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= cmd;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_command(cmd);
        burst_left--;
    endtask

    task automatic wait_drained();
        while (board.expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: stall patterns of its own, plus a long hold on request
    initial begin
        int mode;
        int span;
        int step;
        step = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(posedge i_clk);
                step++;
                if (hold_req) begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                    hold_req = 1'b0;
                end else begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 99) < 30);
                        2: out_stall <= ($urandom_range(0, 99) < 70);
                        default: out_stall <= ((step % 5) < 2);
                    endcase
                end
            end
        end
    end

    // Result monitor and activity count for the watchdog
    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // Watchdog
    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    // Main sequence
    initial begin
        board = new();
        repeat (11) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundaries on empty text, spare opcodes, reads across the gap
        send_cmd(mk(OP_LEFT, 8'h00, '0));
        send_cmd(mk(OP_RIGHT, 8'hFF, '1));
        send_cmd(mk(OP_BKSP, 8'h00, '0));
        send_cmd(mk(OP_READ, 8'h00, '0));
        send_cmd(mk(OP_READ, 8'hFF, '1));
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            send_cmd(mk(3'(op), 8'hFF, '1));
        send_cmd(mk(OP_INSERT, 8'h00, '0));
        send_cmd(mk(OP_INSERT, 8'hFF, '1));
        send_cmd(mk(OP_INSERT, 8'h5A, '0));
        for (int p = 0; p < 4; p++)
            send_cmd(mk(OP_READ, 8'h00, POS_W'(p)));
        repeat (4) send_cmd(mk(OP_LEFT, 8'h00, '0));   // last one hits text start
        send_cmd(mk(OP_READ, 8'h00, POS_W'(0)));
        send_cmd(mk(OP_READ, 8'h00, POS_W'(2)));
        send_cmd(mk(OP_RIGHT, 8'h00, '0));
        send_cmd(mk(OP_BKSP, 8'h00, '0));
        repeat (3) send_cmd(mk(OP_RIGHT, 8'h00, '0));  // last one hits text end

        // Mixed editing; the receiver holds off for a long stretch partway
        for (int n = 0; n < 60; n++) begin
            if (n == 20)
                hold_req = 1'b1;
            send_cmd(random_cmd(40, 10));
        end

        // Sender pauses until every result is back
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
        @(posedge i_clk);

        // Fill the store with plain inserts, then work at full capacity
        while (board.text_total() < CAPACITY)
            send_cmd(mk(OP_INSERT, 8'($urandom_range(0, 255)), '0));
        repeat (12) send_cmd(random_cmd(40, 0));
        while (board.right_len != 0)
            send_cmd(mk(OP_RIGHT, 8'($urandom_range(0, 255)), '0));
        send_cmd(mk(OP_INSERT, 8'hFF, '1));
        send_cmd(mk(OP_READ, 8'h00, '1));

        // Trim the text a little with ordinary editing
        repeat (10) send_cmd(random_cmd(20, 40));

        in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
